>>> sv/three_shear_rotation_mapper_macros.svh
// Assertion macros for the three-shear rotation mapper.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef THREE_SHEAR_ROTATION_MAPPER_MACROS_SVH
`define THREE_SHEAR_ROTATION_MAPPER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSR_ASSERT_NOW(lbl, ante, cons, msg)
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/tsr_pkg.sv
// Shared types and constants of the three-shear rotation mapper.
// No dependencies; imported by tsr_setup, three_shear_rotation_mapper and the testbench.
package tsr_pkg;

    localparam int COORD_W   = 7;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int TAN_DEN_W = 16;
    localparam int SQ_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SIN_NUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_DEN = 2'd1;

    localparam logic [CFG_W-1:0] SIN_NUM_RST = 15'd1;
    localparam logic [CFG_W-1:0] SIN_DEN_RST = 15'd2;

    localparam logic [SQ_W-1:0] SQRT_BIT_INIT = 32'h4000_0000;

    typedef struct packed {
        logic [COORD_W-1:0] in_x;
        logic [COORD_W-1:0] in_y;
    } t_in_word;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               out_valid;
    } t_out_word;

    typedef enum logic [1:0] {
        SU_START,
        SU_SQRT,
        SU_FILL,
        SU_DONE
    } t_setup_state;

    typedef struct packed {
        logic done;
        logic cfg_ok;
    } t_setup_status;

endpackage

>>> sv/three_shear_rotation_mapper.sv
// Throughput: one word per cycle while the output is not stalled and setup is done, through
// four registered stages (row read, x shear, y shear, x shear).
// After reset or a write to either sine register, setup runs a start step, the square root, then
// a sweep writing each table row pair (skipped for an illegal sine ratio); input ready stays low.
// Reset is synchronous, active low; sine registers return to 1/2 and setup restarts.
`include "three_shear_rotation_mapper_macros.svh"

module three_shear_rotation_mapper #(
    parameter int GRID_SIZE = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tsr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tsr_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tsr_pkg::t_in_word                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tsr_pkg::t_out_word                o_out
);
    import tsr_pkg::*;

    localparam int AW = $clog2(GRID_SIZE);
    localparam int TW = AW + 1;
    localparam int SW = ((AW > COORD_W) ? AW : COORD_W) + 2;

    logic [CFG_W-1:0]   r_sin_num;
    logic [CFG_W-1:0]   r_sin_den;
    logic               w_cfg_fire;
    logic               w_restart;

    t_setup_status      w_status;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [TW-1:0]      w_tan_data;
    logic [TW-1:0]      w_sin_data;

    logic [TW-1:0]      r_tan_mem [GRID_SIZE];
    logic [TW-1:0]      r_sin_mem [GRID_SIZE];

    logic               r_v1, r_v2, r_v3, r_v4;
    logic               r_ok1, r_ok2, r_ok3;
    logic [SW-1:0]      r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    logic [TW-1:0]      r_t1, r_s2, r_t3;
    t_out_word          r_out;

    logic               w_en1, w_en2, w_en3, w_en4;
    logic               w_in_fire;
    logic [SW-1:0]      w_in_x, w_in_y;
    logic               w_ok1;
    logic [SW-1:0]      w_x2, w_y3, w_x4;
    logic               w_ok2, w_ok3, w_ok4;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign w_restart   = w_cfg_fire &&
                         ((i_cfg_index == CFG_SIN_NUM) || (i_cfg_index == CFG_SIN_DEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_num <= SIN_NUM_RST;
            r_sin_den <= SIN_DEN_RST;
        end else if (w_cfg_fire) begin
            if (i_cfg_index == CFG_SIN_NUM) begin
                r_sin_num <= i_cfg_data;
            end
            if (i_cfg_index == CFG_SIN_DEN) begin
                r_sin_den <= i_cfg_data;
            end
        end
    end

    tsr_setup #(
        .GRID_SIZE (GRID_SIZE)
    ) u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (w_restart),
        .i_sin_num  (r_sin_num),
        .i_sin_den  (r_sin_den),
        .o_status   (w_status),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_tan_data (w_tan_data),
        .o_sin_data (w_sin_data)
    );

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_tan_mem[w_wr_addr] <= w_tan_data;
            r_sin_mem[w_wr_addr] <= w_sin_data;
        end
    end

    assign w_en4      = !r_v4 || i_out_ready;
    assign w_en3      = !r_v3 || w_en4;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_ready = w_en1 && w_status.done;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_in_x = SW'(i_in.in_x);
    assign w_in_y = SW'(i_in.in_y);
    assign w_ok1  = w_status.cfg_ok && (w_in_x < SW'(GRID_SIZE)) && (w_in_y < SW'(GRID_SIZE));

    assign w_x2  = r_x1 + {{(SW - TW){r_t1[TW-1]}}, r_t1};
    assign w_ok2 = r_ok1 && (w_x2 < SW'(GRID_SIZE));
    assign w_y3  = r_y2 + {{(SW - TW){r_s2[TW-1]}}, r_s2};
    assign w_ok3 = r_ok2 && (w_y3 < SW'(GRID_SIZE));
    assign w_x4  = r_x3 + {{(SW - TW){r_t3[TW-1]}}, r_t3};
    assign w_ok4 = r_ok3 && (w_x4 < SW'(GRID_SIZE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_in_fire;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_ok1 <= w_ok1;
            r_x1  <= w_in_x;
            r_y1  <= w_in_y;
            r_t1  <= r_tan_mem[w_in_y[AW-1:0]];
        end
        if (w_en2) begin
            r_ok2 <= w_ok2;
            r_x2  <= w_x2;
            r_y2  <= r_y1;
            r_s2  <= r_sin_mem[w_x2[AW-1:0]];
        end
        if (w_en3) begin
            r_ok3 <= w_ok3;
            r_x3  <= r_x2;
            r_y3  <= w_y3;
            r_t3  <= r_tan_mem[w_y3[AW-1:0]];
        end
        if (w_en4) begin
            r_out.out_valid <= w_ok4;
            r_out.out_x     <= w_ok4 ? w_x4[COORD_W-1:0] : '0;
            r_out.out_y     <= w_ok4 ? r_y3[COORD_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out       = r_out;

    `TSR_ASSERT_NOW(a_ready_after_setup, o_in_ready, w_status.done, "input ready before setup done")
    `TSR_ASSERT_NEXT(a_write_restarts, w_restart, !w_status.done, "register write did not restart setup")
    `TSR_ASSERT_NOW(a_lost_word_zero, o_out_valid && !o_out.out_valid, (o_out.out_x == '0) && (o_out.out_y == '0), "lost voxel carries nonzero coordinates")

endmodule

>>> sv/tsr_setup.sv
// Setup sequencer: checks the sine ratio, takes the integer square root for the
// cosine, forms the tangent denominator and sweeps both shift tables.
// Depends on tsr_pkg.
module tsr_setup #(
    parameter int GRID_SIZE = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_restart,
    input  logic [tsr_pkg::CFG_W-1:0]             i_sin_num,
    input  logic [tsr_pkg::CFG_W-1:0]             i_sin_den,
    output tsr_pkg::t_setup_status                o_status,
    output logic                                  o_wr_en,
    output logic [$clog2(GRID_SIZE)-1:0]          o_wr_addr,
    output logic [$clog2(GRID_SIZE):0]            o_tan_data,
    output logic [$clog2(GRID_SIZE):0]            o_sin_data
);
    import tsr_pkg::*;

    localparam int AW     = $clog2(GRID_SIZE);
    localparam int TW     = AW + 1;
    localparam int CENTRE = GRID_SIZE / 2;

    t_setup_state            r_state, n_state;
    logic                    r_cfg_ok, n_cfg_ok;
    logic [SQ_W-1:0]         r_rem, n_rem;
    logic [SQ_W-1:0]         r_root, n_root;
    logic [SQ_W-1:0]         r_bit, n_bit;
    logic [TAN_DEN_W-1:0]    r_tan_den, n_tan_den;
    logic [AW-1:0]           r_d, n_d;
    logic                    r_side, n_side;
    logic [TAN_DEN_W-1:0]    r_acc_t, n_acc_t;
    logic [CFG_W-1:0]        r_acc_s, n_acc_s;
    logic [TW-1:0]           r_cnt_t, n_cnt_t;
    logic [TW-1:0]           r_cnt_s, n_cnt_s;

    logic                    w_cfg_ok;
    logic [CFG_W-1:0]        w_diff;
    logic [CFG_W:0]          w_sum;
    logic [SQ_W-1:0]         w_try;
    logic [TAN_DEN_W:0]      w_step_t;
    logic [CFG_W:0]          w_step_s;
    logic [AW:0]             w_pos;
    logic [AW:0]             w_neg;

    assign w_cfg_ok = (i_sin_num != '0) && (i_sin_den != '0) && (i_sin_num <= i_sin_den);
    assign w_diff   = i_sin_den - i_sin_num;
    assign w_sum    = {1'b0, i_sin_den} + {1'b0, i_sin_num};
    assign w_try    = r_root + r_bit;
    assign w_step_t = {1'b0, r_acc_t} + (TAN_DEN_W + 1)'(i_sin_num);
    assign w_step_s = {1'b0, r_acc_s} + {1'b0, i_sin_num};
    assign w_pos    = (AW + 1)'(CENTRE) + {1'b0, r_d};
    assign w_neg    = (AW + 1)'(CENTRE) - {1'b0, r_d};

    always_comb begin
        n_state    = r_state;
        n_cfg_ok   = r_cfg_ok;
        n_rem      = r_rem;
        n_root     = r_root;
        n_bit      = r_bit;
        n_tan_den  = r_tan_den;
        n_d        = r_d;
        n_side     = r_side;
        n_acc_t    = r_acc_t;
        n_acc_s    = r_acc_s;
        n_cnt_t    = r_cnt_t;
        n_cnt_s    = r_cnt_s;
        o_wr_en    = 1'b0;
        o_wr_addr  = w_pos[AW-1:0];
        o_tan_data = '0;
        o_sin_data = '0;
        unique case (r_state)
            SU_START: begin
                n_cfg_ok = w_cfg_ok;
                n_rem    = SQ_W'(w_diff) * SQ_W'(w_sum);
                n_root   = '0;
                n_bit    = SQRT_BIT_INIT;
                n_state  = w_cfg_ok ? SU_SQRT : SU_DONE;
            end
            SU_SQRT: begin
                if (r_bit == '0) begin
                    n_tan_den = TAN_DEN_W'(i_sin_den) + r_root[TAN_DEN_W-1:0];
                    n_d       = '0;
                    n_side    = 1'b0;
                    n_acc_t   = '0;
                    n_acc_s   = '0;
                    n_cnt_t   = '0;
                    n_cnt_s   = '0;
                    n_state   = SU_FILL;
                end else begin
                    if (r_rem >= w_try) begin
                        n_rem  = r_rem - w_try;
                        n_root = (r_root >> 1) + r_bit;
                    end else begin
                        n_root = r_root >> 1;
                    end
                    n_bit = r_bit >> 2;
                end
            end
            SU_FILL: begin
                if (!r_side) begin
                    // advance both floor(d*p/q) counters by one compare and subtract
                    if (r_d != '0) begin
                        if (w_step_t >= {1'b0, r_tan_den}) begin
                            n_acc_t = TAN_DEN_W'(w_step_t - {1'b0, r_tan_den});
                            n_cnt_t = r_cnt_t + TW'(1);
                        end else begin
                            n_acc_t = w_step_t[TAN_DEN_W-1:0];
                        end
                        if (w_step_s >= {1'b0, i_sin_den}) begin
                            n_acc_s = CFG_W'(w_step_s - {1'b0, i_sin_den});
                            n_cnt_s = r_cnt_s + TW'(1);
                        end else begin
                            n_acc_s = w_step_s[CFG_W-1:0];
                        end
                    end
                    o_wr_en    = w_pos < (AW + 1)'(GRID_SIZE);
                    o_wr_addr  = w_pos[AW-1:0];
                    o_tan_data = TW'(0) - n_cnt_t;
                    o_sin_data = n_cnt_s;
                    n_side     = 1'b1;
                end else begin
                    o_wr_en    = 1'b1;
                    o_wr_addr  = w_neg[AW-1:0];
                    o_tan_data = r_cnt_t;
                    o_sin_data = TW'(0) - r_cnt_s;
                    n_side     = 1'b0;
                    if (r_d == AW'(CENTRE)) begin
                        n_state = SU_DONE;
                    end else begin
                        n_d = r_d + AW'(1);
                    end
                end
            end
            SU_DONE: begin
                n_state = SU_DONE;
            end
            default: begin
                n_state = SU_START;
            end
        endcase
        if (i_restart) begin
            n_state = SU_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SU_START;
            r_cfg_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cfg_ok <= n_cfg_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_root    <= n_root;
        r_bit     <= n_bit;
        r_tan_den <= n_tan_den;
        r_d       <= n_d;
        r_side    <= n_side;
        r_acc_t   <= n_acc_t;
        r_acc_s   <= n_acc_s;
        r_cnt_t   <= n_cnt_t;
        r_cnt_s   <= n_cnt_s;
    end

    assign o_status.done   = (r_state == SU_DONE);
    assign o_status.cfg_ok = r_cfg_ok;

endmodule

>>> dv/tb.sv
// Testbench for three_shear_rotation_mapper: random and directed voxel words
// checked against a built-in three-shear predictor, under random stalls.
// Depends on tsr_pkg and the mapper RTL only.
module tb;
    import tsr_pkg::*;

    localparam int GRID        = 128;
    localparam int MID         = GRID / 2;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_word             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_word            o_out;

    three_shear_rotation_mapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    t_in_word  pending_voxels[$];
    t_out_word expected_rotations[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        in_idle_pct = 30;
    int        out_idle_pct = 30;

    logic [CFG_W-1:0]     sine_n = SIN_NUM_RST;
    logic [CFG_W-1:0]     sine_d = SIN_DEN_RST;
    logic [TAN_DEN_W-1:0] half_tan_d = '0;
    bit                   shifts_valid = 1'b0;
    int                   row_shift [GRID];
    int                   col_shift [GRID];

    function automatic bit sine_legal();
        return sine_n != '0 && sine_d != '0 && sine_n <= sine_d;
    endfunction

    function automatic logic [SQ_W-1:0] sqrt_floor(logic [SQ_W-1:0] n);
        logic [SQ_W-1:0] r;
        logic [SQ_W-1:0] b;
        r = '0;
        b = SQRT_BIT_INIT;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void rebuild_shifts();
        logic [SQ_W-1:0] n32;
        logic [SQ_W-1:0] d32;
        int p;
        int q_tan;
        int q_sin;
        int t_tan;
        int t_sin;
        if (!sine_legal()) return;
        n32 = SQ_W'(sine_n);
        d32 = SQ_W'(sine_d);
        half_tan_d = TAN_DEN_W'(d32 + sqrt_floor(d32 * d32 - n32 * n32));
        p = int'(sine_n);
        q_tan = int'(half_tan_d);
        q_sin = int'(sine_d);
        row_shift[MID] = 0;
        col_shift[MID] = 0;
        for (int d = 1; d < GRID; d++) begin
            t_tan = (d * p) / q_tan;
            t_sin = (d * p) / q_sin;
            if (MID + d < GRID) begin
                row_shift[MID + d] = -t_tan;
                col_shift[MID + d] = t_sin;
            end
            if (MID - d >= 0) begin
                row_shift[MID - d] = t_tan;
                col_shift[MID - d] = -t_sin;
            end
        end
        shifts_valid = 1'b1;
    endfunction

    function automatic void take_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_SIN_NUM: begin
                sine_n = data;
                shifts_valid = 1'b0;
            end
            CFG_SIN_DEN: begin
                sine_d = data;
                shifts_valid = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function automatic t_out_word rotate_voxel(t_in_word w);
        t_out_word r;
        int x;
        int y;
        r = '0;
        if (!shifts_valid) rebuild_shifts();
        if (!(shifts_valid && sine_legal())) return r;
        x = int'(w.in_x);
        y = int'(w.in_y);
        x += row_shift[y];
        if (x < 0 || x >= GRID) return r;
        y += col_shift[x];
        if (y < 0 || y >= GRID) return r;
        x += row_shift[y];
        if (x < 0 || x >= GRID) return r;
        r.out_x = COORD_W'(x);
        r.out_y = COORD_W'(y);
        r.out_valid = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_voxels.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                i_in <= pending_voxels.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) take_setting(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) expected_rotations.push_back(rotate_voxel(i_in));
            if (o_out_valid && i_out_ready) begin
                if (expected_rotations.size() == 0) begin
                    $error("unexpected result word %h", o_out);
                    mismatch_count++;
                end else begin
                    want = expected_rotations.pop_front();
                    if (o_out.out_valid !== want.out_valid) begin
                        $error("out_valid: expected %0d, got %0d", want.out_valid,
                               o_out.out_valid);
                        mismatch_count++;
                    end
                    if (o_out.out_x !== want.out_x) begin
                        $error("out_x: expected %0d, got %0d", want.out_x, o_out.out_x);
                        mismatch_count++;
                    end
                    if (o_out.out_y !== want.out_y) begin
                        $error("out_y: expected %0d, got %0d", want.out_y, o_out.out_y);
                        mismatch_count++;
                    end
                end
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
                    || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_voxel(int x, int y);
        t_in_word w;
        w.in_x = COORD_W'(x);
        w.in_y = COORD_W'(y);
        pending_voxels.push_back(w);
    endtask

    // hold until every accepted word has its result, then let the pipe settle
    task automatic drain();
        @(negedge i_clk);
        while (pending_voxels.size() != 0 || expected_rotations.size() != 0 || i_in_valid)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_sine(logic [CFG_W-1:0] n, logic [CFG_W-1:0] d);
        if ($urandom_range(1)) begin
            write_reg(CFG_SIN_NUM, n);
            write_reg(CFG_SIN_DEN, d);
        end else begin
            write_reg(CFG_SIN_DEN, d);
            write_reg(CFG_SIN_NUM, n);
        end
    endtask

    task automatic random_setting();
        logic [CFG_W-1:0] d;
        logic [CFG_W-1:0] n;
        int pick;
        d = CFG_W'($urandom_range(1, (1 << $urandom_range(1, CFG_W)) - 1));
        n = CFG_W'($urandom_range(1, d));
        pick = $urandom_range(7);
        if (pick == 0) begin
            n = '0;
        end else if (pick == 1 && d < 15'h7fff) begin
            n = CFG_W'(d + $urandom_range(1, 32767 - d));
        end
        write_sine(n, d);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_voxel(0, 0);
        push_voxel(127, 127);
        push_voxel(0, 127);
        push_voxel(127, 0);
        push_voxel(MID, MID);
        push_voxel(MID, 0);
        push_voxel(0, MID);
        push_voxel(MID - 1, MID + 1);
        push_voxel(100, 30);
        drain();

        write_sine(15'h7fff, 15'h7fff);
        push_voxel(MID, MID);
        push_voxel(MID + 20, MID - 10);
        push_voxel(127, 127);
        push_voxel(0, 0);
        drain();

        write_sine(15'd1, 15'h7fff);
        push_voxel(0, 0);
        push_voxel(127, 127);
        push_voxel(MID, 127);
        drain();

        write_sine(15'd0, 15'd5);
        push_voxel(MID, MID);
        push_voxel(10, 90);
        drain();
        write_sine(15'd3, 15'd0);
        push_voxel(MID, MID);
        push_voxel(90, 10);
        drain();
        write_sine(15'd9, 15'd4);
        push_voxel(MID, MID);
        push_voxel(70, 60);
        drain();

        write_sine(15'd3, 15'd4);
        write_reg(CFG_IDX_SPARE_LO, CFG_W'($urandom));
        write_reg(CFG_IDX_SPARE_HI, CFG_W'($urandom));
        push_voxel(MID + 30, MID + 30);
        push_voxel(20, 40);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            random_setting();
            if (ph == 2) begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct = 30;
                out_idle_pct = 30;
            end
            repeat (152) push_voxel($urandom_range(GRID - 1), $urandom_range(GRID - 1));
            drain();
        end

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
